// ===== src/code39_barcode_element_encoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Code 39 element encoder - assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CODE39_BARCODE_ELEMENT_ENCODER_UNIT_ASSERT_SVH
`define CODE39_BARCODE_ELEMENT_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CBE_PROP(prop) @(posedge clk) disable iff (rst) prop
`define CBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (`CBE_PROP(prop)) else $error(msg);
`else
`define CBE_PROP(prop)
`define CBE_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== src/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg
// Types, constants and symbol tables of the Code 39 element encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbe_pkg;

  typedef logic [5:0] sym_t;

  localparam int MAX_SYMS    = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam sym_t SYM_DOLLAR    = 6'd39;
  localparam sym_t SYM_SLASH     = 6'd40;
  localparam sym_t SYM_PLUS      = 6'd41;
  localparam sym_t SYM_PERCENT   = 6'd42;
  localparam sym_t SYM_STARTSTOP = 6'd43;
  localparam logic [6:0] MOD_BASE = 7'd43;

  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;
  localparam logic [7:0] ESC_LO      = 8'h5B;
  localparam logic [7:0] ESC_CODE_LO = 8'h40;
  localparam logic [7:0] ESC_CODE_HI = 8'h5F;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_FIVE   = 8'h35;
  localparam logic [6:0] CHAR_DEL    = 7'h7F;

  localparam logic [3:0] ELEM_LAST_BAR = 4'd8;
  localparam logic [3:0] ELEM_GAP      = 4'd9;

  localparam logic [8:0] PATTERNS [44] = '{
    9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
    9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
    9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
    9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0,
    9'h085, 9'h184, 9'h0C4, 9'h0A8, 9'h0A2, 9'h08A, 9'h02A, 9'h094
  };

  typedef struct packed {
    logic       checksum_enable;
    logic       full_ascii;
    logic [6:0] escape_char;
  } cfg_t;

  typedef struct packed {
    logic                      err;
    logic                      has_stop;
    logic [2:0]                count;
    sym_t [MAX_SYMS-1:0]       syms;
  } job_t;

  typedef struct packed {
    logic valid;
    sym_t sym;
  } sym_lookup_t;

  typedef struct packed {
    logic [1:0] count;
    sym_t       s0;
    sym_t       s1;
  } expand_t;

  function automatic sym_lookup_t sym_of(input logic [7:0] c);
    sym_lookup_t r;
    r.valid = 1'b1;
    r.sym   = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.sym = 6'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      r.sym = 6'(c - 8'h37);
    end else begin
      unique case (c)
        8'h2D: r.sym = 6'd36;
        8'h2E: r.sym = 6'd37;
        8'h20: r.sym = 6'd38;
        8'h24: r.sym = SYM_DOLLAR;
        8'h2F: r.sym = SYM_SLASH;
        8'h2B: r.sym = SYM_PLUS;
        8'h25: r.sym = SYM_PERCENT;
        default: r.valid = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic logic is_direct(input logic [6:0] c);
    return (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
           c == 7'h20 || c == 7'h2D || c == 7'h2E;
  endfunction

  // full-ASCII expansion into a direct symbol, or a shift symbol and a letter symbol
  function automatic expand_t expand(input logic [6:0] c);
    expand_t     r;
    sym_lookup_t lk;
    logic [7:0]  cc;
    logic [7:0]  lt;
    cc = {1'b0, c};
    lt = '0;
    lk = sym_of(cc);
    r.count = 2'd2;
    r.s0    = SYM_PERCENT;
    r.s1    = '0;
    if (is_direct(c)) begin
      r.count = 2'd1;
      r.s0    = lk.sym;
    end else begin
      priority if (cc == 8'd0) begin
        lt = 8'd30;
      end else if (cc <= 8'd26) begin
        r.s0 = SYM_DOLLAR; lt = cc + 8'd9;
      end else if (cc <= 8'd31) begin
        lt = cc - 8'd17;
      end else if (cc <= 8'd44) begin
        r.s0 = SYM_SLASH; lt = cc - 8'd23;
      end else if (cc == 8'd47) begin
        r.s0 = SYM_SLASH; lt = 8'd24;
      end else if (cc == 8'd58) begin
        r.s0 = SYM_SLASH; lt = 8'd35;
      end else if (cc <= 8'd63) begin
        lt = cc - 8'd44;
      end else if (cc == 8'd64) begin
        lt = 8'd31;
      end else if (cc <= 8'd95) begin
        lt = cc - 8'd71;
      end else if (cc == 8'd96) begin
        lt = 8'd32;
      end else if (cc <= 8'd122) begin
        r.s0 = SYM_PLUS; lt = cc - 8'd87;
      end else begin
        lt = cc - 8'd98;
      end
      r.s1 = 6'(lt);
    end
    return r;
  endfunction

  function automatic sym_t add_mod43(input sym_t a, input sym_t b);
    logic [6:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= MOD_BASE) ? 6'(s - MOD_BASE) : 6'(s);
  endfunction

  function automatic logic [8:0] pattern(input sym_t s);
    return PATTERNS[(s < 6'd44) ? s : SYM_STARTSTOP];
  endfunction

endpackage

`default_nettype wire

// ===== src/cbe_channels.sv =====
// ----------------------------------------------------------------------------
// cbe_in_if / cbe_out_if
// Valid/ready channels for message characters and bar/space elements.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_message;

  modport source (output valid, char_in, end_of_message, input ready);
  modport sink (input valid, char_in, end_of_message, output ready);
endinterface

interface cbe_out_if #(
  parameter int DOT_WIDTH_BITS = 6
);
  logic                      valid;
  logic                      ready;
  logic                      is_bar;
  logic [DOT_WIDTH_BITS-1:0] width;
  logic [5:0]                symbol;
  logic                      error;
  logic                      message_done;
  logic                      last;

  modport source (output valid, is_bar, width, symbol, error, message_done, last,
                  input ready);
  modport sink (input valid, is_bar, width, symbol, error, message_done, last,
                output ready);
endinterface

`default_nettype wire

// ===== src/code39_barcode_element_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// code39_barcode_element_encoder_unit
// Code 39 bar/space element encoder with full-ASCII and mod-43 check.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one message character per transaction (char_in, end_of_message).
//   out_ch : one bar or space element per transaction (is_bar, width in dots,
//            symbol, error, message_done, last on the final element of a char).
//   APB    : five registers at byte offsets 0x00..0x10, written while idle.
// A character is taken whenever the two-entry job queue has room; its job is
// written into the queue and its first element then enters the output register.
// Elements leave at one per cycle while the receiver is ready, 10 per symbol
// and 9 for the stop, so a character yields 0 (escape, dropped) to 49
// elements, 1 on an error; the serializer sets the rate.
// Reset clears message state, the queue and the output register, and loads
// register defaults. When the receiver stalls, the output register holds
// its element, the serializer waits, and the input stalls once the queue
// is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module code39_barcode_element_encoder_unit import cbe_pkg::*; #(
  parameter int DOT_WIDTH_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  cbe_in_if.sink      in_ch,
  cbe_out_if.source   out_ch
);

  localparam logic [2:0] REG_CHECKSUM_ENABLE = 3'd0;
  localparam logic [2:0] REG_FULL_ASCII      = 3'd1;
  localparam logic [2:0] REG_NARROW_WIDTH    = 3'd2;
  localparam logic [2:0] REG_WIDE_WIDTH      = 3'd3;
  localparam logic [2:0] REG_ESCAPE_CHAR     = 3'd4;

  cfg_t                      cfg;
  logic [DOT_WIDTH_BITS-1:0] narrow_width;
  logic [DOT_WIDTH_BITS-1:0] wide_width;
  logic                      cfg_write;
  logic [2:0]                reg_sel;

  logic                      push;
  job_t                      push_job;
  logic                      queue_full;
  logic                      pop;
  logic                      head_valid;
  job_t                      head;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.checksum_enable <= 1'b0;
      cfg.full_ascii      <= 1'b0;
      cfg.escape_char     <= 7'd94;
      narrow_width        <= DOT_WIDTH_BITS'(2);
      wide_width          <= DOT_WIDTH_BITS'(6);
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CHECKSUM_ENABLE: cfg.checksum_enable <= pwdata[0];
        REG_FULL_ASCII:      cfg.full_ascii      <= pwdata[0];
        REG_NARROW_WIDTH:    narrow_width        <= DOT_WIDTH_BITS'(pwdata[5:0]);
        REG_WIDE_WIDTH:      wide_width          <= DOT_WIDTH_BITS'(pwdata[5:0]);
        REG_ESCAPE_CHAR:     cfg.escape_char     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CHECKSUM_ENABLE: prdata = 32'(cfg.checksum_enable);
      REG_FULL_ASCII:      prdata = 32'(cfg.full_ascii);
      REG_NARROW_WIDTH:    prdata = 32'(narrow_width);
      REG_WIDE_WIDTH:      prdata = 32'(wide_width);
      REG_ESCAPE_CHAR:     prdata = 32'(cfg.escape_char);
      default:             prdata = '0;
    endcase
  end

  cbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  cbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cbe_back #(
    .DOT_WIDTH_BITS (DOT_WIDTH_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .narrow_width (narrow_width),
    .wide_width   (wide_width),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/cbe_queue.sv =====
// ----------------------------------------------------------------------------
// cbe_queue
// Small register queue of symbol jobs between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbe_queue import cbe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full       = (count == CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cbe_front.sv =====
// ----------------------------------------------------------------------------
// cbe_front
// Accepts characters, tracks message state and builds symbol jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbe_front import cbe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  cbe_in_if.sink in_ch,
  input  logic queue_full,
  output logic push,
  output job_t push_job
);

  logic        in_message;
  logic [5:0]  check_sum;
  logic        escape_pending;
  logic        discarding;

  logic        accept;
  logic [7:0]  c;
  logic        eom;
  logic        bad;
  logic        esc_start;
  logic [6:0]  code;
  expand_t     ex;
  sym_lookup_t lk;
  logic        start;
  sym_t        cs_base;
  sym_t        cs1;
  sym_t        cs2;
  job_t        job;
  logic [2:0]  n;

  assign c           = in_ch.char_in;
  assign eom         = in_ch.end_of_message;
  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && !queue_full;

  always_comb begin
    bad       = 1'b0;
    esc_start = 1'b0;
    code      = '0;
    ex        = '0;
    lk        = sym_of(c);
    if (escape_pending) begin
      priority if (c >= ESC_CODE_LO && c <= ESC_CODE_HI) begin
        code = 7'(c - ESC_CODE_LO);
      end else if (c == CHAR_ZERO) begin
        code = cfg.escape_char;
      end else if (c == CHAR_FIVE) begin
        code = CHAR_DEL;
      end else begin
        bad = 1'b1;
      end
      if (!bad) begin
        ex = expand(code);
      end
    end else if (cfg.full_ascii) begin
      priority if (c < PRINT_LO || c > PRINT_HI) begin
        bad = 1'b1;
      end else if (c >= ESC_LO && c == {1'b0, cfg.escape_char}) begin
        bad       = eom;
        esc_start = !eom;
      end else begin
        ex = expand(c[6:0]);
      end
    end else begin
      if (!lk.valid) begin
        bad = 1'b1;
      end else begin
        ex.count = 2'd1;
        ex.s0    = lk.sym;
      end
    end
  end

  assign start   = !in_message;
  assign cs_base = start ? '0 : check_sum;
  assign cs1     = add_mod43(cs_base, (ex.count != 2'd0) ? ex.s0 : '0);
  assign cs2     = add_mod43(cs1, (ex.count == 2'd2) ? ex.s1 : '0);

  always_comb begin
    job = '0;
    n   = '0;
    if (bad) begin
      job.err = 1'b1;
    end else begin
      if (start) begin
        job.syms[n] = SYM_STARTSTOP;
        n = n + 3'd1;
      end
      if (ex.count != 2'd0) begin
        job.syms[n] = ex.s0;
        n = n + 3'd1;
      end
      if (ex.count == 2'd2) begin
        job.syms[n] = ex.s1;
        n = n + 3'd1;
      end
      if (eom) begin
        if (cfg.checksum_enable) begin
          job.syms[n] = cs2;
          n = n + 3'd1;
        end
        job.syms[n]  = SYM_STARTSTOP;
        n            = n + 3'd1;
        job.has_stop = 1'b1;
      end
    end
    job.count = n;
  end

  assign push     = accept && !discarding && (bad || n != 3'd0);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_message     <= 1'b0;
      check_sum      <= '0;
      escape_pending <= 1'b0;
      discarding     <= 1'b0;
    end else if (accept) begin
      priority if (discarding) begin
        discarding <= !eom;
      end else if (bad || eom) begin
        in_message     <= 1'b0;
        check_sum      <= '0;
        escape_pending <= 1'b0;
        discarding     <= bad && !eom;
      end else begin
        in_message     <= 1'b1;
        check_sum      <= cs2;
        escape_pending <= esc_start;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/cbe_back.sv =====
// ----------------------------------------------------------------------------
// cbe_back
// Serializes queued symbol jobs into bar/space elements, one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "code39_barcode_element_encoder_unit_assert.svh"

module cbe_back import cbe_pkg::*; #(
  parameter int DOT_WIDTH_BITS = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [DOT_WIDTH_BITS-1:0] narrow_width,
  input  logic [DOT_WIDTH_BITS-1:0] wide_width,
  input  logic                      head_valid,
  input  job_t                      head,
  output logic                      pop,
  cbe_out_if.source                 out_ch
);

  logic [3:0]                elem;
  logic [2:0]                slot;
  logic                      out_valid;

  logic [DOT_WIDTH_BITS-1:0] nw;
  logic [DOT_WIDTH_BITS-1:0] ww;
  sym_t                      sym;
  logic [8:0]                pat;
  logic                      last_sym;
  logic                      stop_sym;
  logic                      sym_end;
  logic                      load;

  assign nw       = (narrow_width == '0) ? DOT_WIDTH_BITS'(1) : narrow_width;
  assign ww       = (wide_width == '0) ? DOT_WIDTH_BITS'(1) : wide_width;
  assign sym      = head.syms[slot];
  assign pat      = pattern(sym);
  assign last_sym = (slot == 3'(head.count - 3'd1));
  assign stop_sym = last_sym && head.has_stop;
  assign sym_end  = (elem == (stop_sym ? ELEM_LAST_BAR : ELEM_GAP));
  assign load     = head_valid && (!out_valid || out_ch.ready);
  assign pop      = load && (head.err || (sym_end && last_sym));

  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      elem      <= '0;
      slot      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (load && !head.err) begin
        if (sym_end) begin
          elem <= '0;
          slot <= last_sym ? '0 : slot + 3'd1;
        end else begin
          elem <= elem + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.err) begin
        out_ch.is_bar       <= 1'b0;
        out_ch.width        <= '0;
        out_ch.symbol       <= '0;
        out_ch.error        <= 1'b1;
        out_ch.message_done <= 1'b1;
        out_ch.last         <= 1'b1;
      end else begin
        out_ch.is_bar       <= (elem != ELEM_GAP) && !elem[0];
        out_ch.width        <= (elem != ELEM_GAP && pat[4'(ELEM_LAST_BAR - elem)]) ? ww : nw;
        out_ch.symbol       <= sym;
        out_ch.error        <= 1'b0;
        out_ch.message_done <= stop_sym && (elem == ELEM_LAST_BAR);
        out_ch.last         <= sym_end && last_sym;
      end
    end
  end

  `CBE_ASSERT(a_err_result, out_valid && out_ch.error |-> out_ch.last && out_ch.message_done && out_ch.width == '0, "error result malformed")
  `CBE_ASSERT(a_stop_done, out_valid && out_ch.message_done && !out_ch.error |-> out_ch.symbol == SYM_STARTSTOP && out_ch.last && out_ch.is_bar, "message end not on stop bar")
  `CBE_ASSERT(a_pop_ends, pop && !head.err |-> sym_end && last_sym && (head.has_stop || elem == ELEM_GAP), "job popped mid symbol")

endmodule

`default_nettype wire

// ===== tb/code39_barcode_element_encoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// code39_barcode_element_encoder_unit_tb
// Streams message characters into the Code 39 element encoder, predicts every
// bar/space element in a scoreboard and checks each output transaction
// field by field. Covers basic and full-ASCII modes, escapes, check symbols,
// invalid characters with message discard, width extremes and backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module code39_barcode_element_encoder_unit_tb;

  typedef enum int {
    REG_CHECKSUM_ENABLE,
    REG_FULL_ASCII,
    REG_NARROW_WIDTH,
    REG_WIDE_WIDTH,
    REG_ESCAPE_CHAR
  } cfg_reg_e;

  typedef struct packed {
    logic          is_bar;
    logic [5:0]    width;
    cbe_pkg::sym_t symbol;
    logic          error;
    logic          message_done;
    logic          last;
  } element_t;

  localparam int    START_STOP   = 43;
  localparam int    NUM_DIRECT   = 39;
  localparam int    CODE_DEL     = 8'h7F;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    DRAIN_CYCLES = 12;
  localparam string CODE39_CHARS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%";

  localparam logic [8:0] BAR_PATTERN [44] = '{
    9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
    9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
    9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
    9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0,
    9'h085, 9'h184, 9'h0C4, 9'h0A8, 9'h0A2, 9'h08A, 9'h02A, 9'h094
  };

  class code39_scoreboard;
    element_t expected_q[$];
    int       errors;
    bit       checksum_enable;
    bit       full_ascii;
    bit [5:0] narrow_width;
    bit [5:0] wide_width;
    bit [6:0] escape_char;
    bit       in_message;
    bit       escape_pending;
    bit       discarding;
    int       check_sum;

    function new();
      checksum_enable = 0;
      full_ascii      = 0;
      narrow_width    = 2;
      wide_width      = 6;
      escape_char     = 94;
      in_message      = 0;
      escape_pending  = 0;
      discarding      = 0;
      check_sum       = 0;
      errors          = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [31:0] value);
      case (idx)
        REG_CHECKSUM_ENABLE: checksum_enable = value[0];
        REG_FULL_ASCII:      full_ascii      = value[0];
        REG_NARROW_WIDTH:    narrow_width    = value[5:0];
        REG_WIDE_WIDTH:      wide_width      = value[5:0];
        REG_ESCAPE_CHAR:     escape_char     = value[6:0];
        default: ;
      endcase
    endfunction

    function int symbol_index(int c);
      for (int i = 0; i < START_STOP; i++) begin
        if (CODE39_CHARS[i] == c) return i;
      end
      return -1;
    endfunction

    // full-ASCII code: a direct symbol, or a shift symbol then a letter
    function void expand_code(int c, output int n, output int s0, output int s1);
      int shift;
      int letter;
      int d;
      d = symbol_index(c);
      s1 = 0;
      if (d >= 0 && d < NUM_DIRECT) begin
        n = 1;
        s0 = d;
        return;
      end
      n = 2;
      if (c == 0) begin
        shift = "%"; letter = "U";
      end else if (c <= 26) begin
        shift = "$"; letter = "A" + c - 1;
      end else if (c <= 31) begin
        shift = "%"; letter = "A" + c - 27;
      end else if (c <= 44) begin
        shift = "/"; letter = "A" + c - 33;
      end else if (c == 47) begin
        shift = "/"; letter = "O";
      end else if (c == 58) begin
        shift = "/"; letter = "Z";
      end else if (c <= 63) begin
        shift = "%"; letter = "F" + c - 59;
      end else if (c == 64) begin
        shift = "%"; letter = "V";
      end else if (c <= 95) begin
        shift = "%"; letter = "K" + c - 91;
      end else if (c == 96) begin
        shift = "%"; letter = "W";
      end else if (c <= 122) begin
        shift = "+"; letter = c - 32;
      end else begin
        shift = "%"; letter = "P" + c - 123;
      end
      s0 = symbol_index(shift);
      s1 = symbol_index(letter);
    endfunction

    function void push_symbol(int sym, bit gap, bit done);
      logic [8:0] pat;
      bit [5:0]   nw;
      bit [5:0]   ww;
      element_t   e;
      pat = BAR_PATTERN[sym];
      nw  = (narrow_width == 0) ? 6'd1 : narrow_width;
      ww  = (wide_width == 0) ? 6'd1 : wide_width;
      e.symbol = sym;
      e.error  = 1'b0;
      e.last   = 1'b0;
      for (int i = 0; i < 9; i++) begin
        e.is_bar       = (i % 2 == 0);
        e.width        = pat[8-i] ? ww : nw;
        e.message_done = done && (i == 8);
        expected_q.push_back(e);
      end
      if (gap) begin
        e.is_bar       = 1'b0;
        e.width        = nw;
        e.message_done = 1'b0;
        expected_q.push_back(e);
      end
    endfunction

    // accepted input transaction -> expected elements
    function void note_char(logic [7:0] ch, logic eom);
      int c;
      int n;
      int syms[2];
      int code;
      int first;
      bit bad;
      bit esc_start;
      c = ch;
      n = 0;
      code = 0;
      bad = 0;
      esc_start = 0;
      first = expected_q.size();
      if (discarding) begin
        if (eom) discarding = 0;
        return;
      end
      if (escape_pending) begin
        escape_pending = 0;
        if (c >= 8'h40 && c <= 8'h5F) code = c - 8'h40;
        else if (c == "0") code = escape_char;
        else if (c == "5") code = CODE_DEL;
        else bad = 1;
        if (!bad) expand_code(code, n, syms[0], syms[1]);
      end else if (full_ascii) begin
        if (c < 8'h20 || c > 8'h7E) bad = 1;
        else if (c >= 8'h5B && c == escape_char) begin
          if (eom) bad = 1;
          else esc_start = 1;
        end else expand_code(c, n, syms[0], syms[1]);
      end else begin
        syms[0] = symbol_index(c);
        if (syms[0] < 0) bad = 1;
        else n = 1;
      end
      if (bad) begin
        expected_q.push_back('{1'b0, 6'd0, 6'd0, 1'b1, 1'b1, 1'b1});
        in_message     = 0;
        check_sum      = 0;
        escape_pending = 0;
        discarding     = !eom;
        return;
      end
      if (!in_message) begin
        push_symbol(START_STOP, 1, 0);
        in_message = 1;
        check_sum  = 0;
      end
      if (esc_start) escape_pending = 1;
      for (int k = 0; k < n; k++) begin
        push_symbol(syms[k], 1, 0);
        check_sum = (check_sum + syms[k]) % START_STOP;
      end
      if (eom) begin
        if (checksum_enable) push_symbol(check_sum, 1, 0);
        push_symbol(START_STOP, 0, 1);
        in_message     = 0;
        check_sum      = 0;
        escape_pending = 0;
      end
      if (expected_q.size() > first) expected_q[expected_q.size()-1].last = 1'b1;
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check(element_t got);
      element_t want;
      if (expected_q.size() == 0) begin
        $error("element with no expectation pending: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("is_bar", want.is_bar, got.is_bar);
      compare("width", want.width, got.width);
      compare("symbol", want.symbol, got.symbol);
      compare("error", want.error, got.error);
      compare("message_done", want.message_done, got.message_done);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cbe_in_if                        in_ch ();
  cbe_out_if #(.DOT_WIDTH_BITS(6)) out_ch ();

  code39_barcode_element_encoder_unit #(.DOT_WIDTH_BITS(6)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  code39_scoreboard sb;
  bit               send_idle    = 1;
  bit               recv_idle    = 1;
  bit               hold_request = 0;
  int               items_sent   = 0;

  always #1 clk = ~clk;

  task automatic send_char(input logic [7:0] ch, input logic eom);
    int gap;
    gap = send_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.char_in        <= ch;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_char(ch, eom);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit eom);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eom && (i == s.len() - 1));
  endtask

  // mostly well-formed messages, some noise bytes and escape sequences
  task automatic send_message();
    int          len;
    int          r;
    int          q;
    logic [7:0]  ch;
    bit          eom;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      eom = (i == len - 1);
      r = $urandom_range(0, 19);
      if (r == 0) begin
        ch = $urandom_range(0, 255);
      end else if (sb.full_ascii && r <= 3 && !eom) begin
        send_char({1'b0, sb.escape_char}, 1'b0);
        q = $urandom_range(0, 9);
        if (q == 0) ch = $urandom_range(0, 255);
        else if (q == 1) ch = "0";
        else if (q == 2) ch = "5";
        else ch = $urandom_range(8'h40, 8'h5F);
      end else if (sb.full_ascii) begin
        ch = $urandom_range(8'h20, 8'h7E);
      end else begin
        ch = CODE39_CHARS[$urandom_range(0, START_STOP - 1)];
      end
      send_char(ch, eom);
    end
  endtask

  task automatic apb_write(input cfg_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, value);
  endtask

  task automatic configure(input bit cks, input bit fa, input int nar, input int wid,
                           input int esc);
    apb_write(REG_CHECKSUM_ENABLE, cks);
    apb_write(REG_FULL_ASCII, fa);
    apb_write(REG_NARROW_WIDTH, nar);
    apb_write(REG_WIDE_WIDTH, wid);
    apb_write(REG_ESCAPE_CHAR, esc);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid, drain expected elements, then let no-result items settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : element_sink
    int       stall;
    element_t got;
    out_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 0;
      end else begin
        stall = recv_idle ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got = '{out_ch.is_bar, out_ch.width, out_ch.symbol, out_ch.error,
              out_ch.message_done, out_ch.last};
      sb.check(got);
    end
  end

  initial begin : stimulus
    int target;
    sb = new();
    in_ch.valid          <= 1'b0;
    in_ch.char_in        <= 8'h00;
    in_ch.end_of_message <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // basic mode at reset settings: every non-alphanumeric symbol
    send_text("A09Z-. $/+%", 1);
    // invalid char mid-message, remainder dropped up to end of message
    send_text("1*2", 1);
    send_char(8'hFF, 1);
    wait_idle();

    // full ASCII with check symbol: lowercase, escapes, DEL, escape as last char
    configure(1, 1, 1, 63, 94);
    send_text("a~^@^0^5", 1);
    send_char("^", 1);
    send_char(8'h00, 1);
    // escape completes after full-ASCII is switched off
    send_char("^", 0);
    wait_idle();
    configure(1, 0, 1, 63, 94);
    send_char("_", 1);

    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      if (phase == 0) configure(1, 0, 0, 0, 94);
      else if (phase == 1) configure(0, 1, 63, 1, 91);
      else if (phase == 2) configure(1, 1, 1, 63, 126);
      else configure($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(1, 63),
                     $urandom_range(1, 63), $urandom_range(91, 126));
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      if (phase == 5) begin
        send_idle = 0;
        hold_request = 1;
      end
      target = items_sent + 36;
      while (items_sent < target) send_message();
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("[code39_barcode_element_encoder_unit] OK");
    end else begin
      $display("[code39_barcode_element_encoder_unit] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("[code39_barcode_element_encoder_unit] ERROR");
    $finish;
  end

endmodule

// ===== code39_barcode_element_encoder_unit.f =====
+incdir+src
src/cbe_pkg.sv
src/cbe_channels.sv
src/cbe_queue.sv
src/cbe_front.sv
src/cbe_back.sv
src/code39_barcode_element_encoder_unit.sv
tb/code39_barcode_element_encoder_unit_tb.sv
